### rtl/core/vfr_pkg.sv
// ----------------------------------------------------------------------------
// vfr_pkg
// Shared types and constants of the varint field reader.
// ----------------------------------------------------------------------------
package vfr_pkg;

  localparam int unsigned POS_W  = 16;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CMP_W  = 33;
  localparam int unsigned ADDR_W = 3;

  localparam logic [2:0] OPC_V32    = 3'd0;
  localparam logic [2:0] OPC_V64    = 3'd1;
  localparam logic [2:0] OPC_F32    = 3'd2;
  localparam logic [2:0] OPC_LEN    = 3'd3;
  localparam logic [2:0] OPC_REWIND = 3'd4;

  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_EMPTY = 2'd2;

  localparam logic [0:0] REG_BUFFER_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    OP_V32,
    OP_V64,
    OP_F32,
    OP_LEN,
    OP_REWIND,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [63:0] value_bits;
    logic [7:0]  payload_byte;
    logic        payload_last;
  } out_t;

  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } cmd_t;

endpackage

### rtl/core/varint_field_reader.sv
// ----------------------------------------------------------------------------
// varint_field_reader
// Reads varints, float bit patterns and length-prefixed fields from a
// byte stream, one buffer byte per item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) carries an opcode and
//   the next buffer byte. Output channel (out_valid_o/out_ready_i/
//   out_item_o) carries finished values, payload bytes and empty-field
//   results. buffer_length is written over the APB port at address 0;
//   the user must write it only while the block is idle; the block does not enforce this.
//   An accepted item is written into the queue, executed from its head and
//   its result, if any, is registered in the result register. One item per
//   cycle is sustained while the receiver does not hold off.
//   A two-entry queue between the decode and execute stages and a result
//   register let both sides stall independently: while the receiver holds
//   off, the queue fills and then in_ready_o drops.
//   Reset clears the read position, the read state, the queue and the
//   buffer length; in_ready_o is high as soon as reset is released.
// ----------------------------------------------------------------------------
module varint_field_reader (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  vfr_pkg::in_t                  in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output vfr_pkg::out_t                 out_item_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vfr_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [vfr_pkg::LEN_W-1:0] buf_len_q;
  logic                      cmd_valid;
  logic                      cmd_ready;
  vfr_pkg::cmd_t             cmd;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == vfr_pkg::REG_BUFFER_LENGTH) ? 32'(buf_len_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_len_q <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == vfr_pkg::REG_BUFFER_LENGTH) begin
      buf_len_q <= pwdata[vfr_pkg::LEN_W-1:0];
    end
  end

  vfr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  vfr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .buffer_length_i (buf_len_q),
    .cmd_valid_i     (cmd_valid),
    .cmd_ready_o     (cmd_ready),
    .cmd_i           (cmd),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_item_o      (out_item_o)
  );

endmodule

### rtl/core/vfr_front.sv
// ----------------------------------------------------------------------------
// vfr_front
// Accept items, decode the opcode and hold them in a two-entry queue.
// ----------------------------------------------------------------------------
module vfr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  vfr_pkg::in_t    in_item_i,
  output logic            cmd_valid_o,
  input  logic            cmd_ready_i,
  output vfr_pkg::cmd_t   cmd_o
);

  vfr_pkg::cmd_t entry_q [2];
  vfr_pkg::cmd_t new_cmd;
  logic [1:0]    count_q, count_d;
  logic          wr_ptr_q, rd_ptr_q;
  logic          push, pop;

  always_comb begin
    new_cmd.data = in_item_i.data_byte;
    unique case (in_item_i.opcode)
      vfr_pkg::OPC_V32:    new_cmd.op = vfr_pkg::OP_V32;
      vfr_pkg::OPC_V64:    new_cmd.op = vfr_pkg::OP_V64;
      vfr_pkg::OPC_F32:    new_cmd.op = vfr_pkg::OP_F32;
      vfr_pkg::OPC_LEN:    new_cmd.op = vfr_pkg::OP_LEN;
      vfr_pkg::OPC_REWIND: new_cmd.op = vfr_pkg::OP_REWIND;
      default:             new_cmd.op = vfr_pkg::OP_NONE;
    endcase
  end

  assign in_ready_o  = (count_q != 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");
  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count missed a push");
`endif

endmodule

### rtl/core/vfr_back.sv
// ----------------------------------------------------------------------------
// vfr_back
// Execute queued items against the read state and register the results.
// ----------------------------------------------------------------------------
module vfr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [vfr_pkg::LEN_W-1:0]   buffer_length_i,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  vfr_pkg::cmd_t               cmd_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output vfr_pkg::out_t               out_item_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_V32,
    PH_V32_SKIP,
    PH_V64,
    PH_F32,
    PH_LEN,
    PH_LEN_SKIP,
    PH_PAY
  } phase_e;

  localparam int unsigned PW = vfr_pkg::POS_W;
  localparam int unsigned CW = vfr_pkg::CMP_W;

  phase_e                          phase_q, phase_d;
  logic [63:0]                     acc_q, acc_d;
  logic [3:0]                      cnt_q, cnt_d;
  logic [PW-1:0]                   pos_q, pos_d;
  logic [vfr_pkg::LEN_W-1:0]       rem_q, rem_d;
  logic                            out_valid_q, out_valid_d;
  vfr_pkg::out_t                   out_q, out_d;
  logic                            take;

  assign cmd_ready_o = !out_valid_q || out_ready_i;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    logic              active;
    logic              in_buf;
    logic [7:0]        b;
    logic [CW-1:0]     len_x;
    logic [CW-1:0]     pos_x;
    logic [CW-1:0]     room;
    logic [31:0]       v;
    logic              fin32;
    logic              is_len;
    logic [5:0]        sh7;
    logic [4:0]        sh8;
    logic              emit;
    vfr_pkg::out_t     res;

    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    rem_d   = rem_q;
    active  = 1'b1;
    fin32   = 1'b0;
    is_len  = 1'b0;
    emit    = 1'b0;
    res     = '0;
    b       = 8'd0;
    v       = 32'd0;
    room    = '0;
    sh7     = 6'd0;
    sh8     = 5'd0;
    len_x   = CW'(buffer_length_i);
    pos_x   = CW'(pos_q);
    in_buf  = 1'b0;

    if (phase_q == PH_IDLE) begin
      acc_d = 64'd0;
      cnt_d = 4'd0;
      unique case (cmd_i.op)
        vfr_pkg::OP_V32: phase_d = PH_V32;
        vfr_pkg::OP_V64: phase_d = PH_V64;
        vfr_pkg::OP_F32: phase_d = PH_F32;
        vfr_pkg::OP_LEN: phase_d = PH_LEN;
        vfr_pkg::OP_REWIND: begin
          active = 1'b0;
          pos_d  = '0;
          acc_d  = acc_q;
          cnt_d  = cnt_q;
        end
        default: begin
          active = 1'b0;
          acc_d  = acc_q;
          cnt_d  = cnt_q;
        end
      endcase
    end

    if (active) begin
      in_buf = pos_x < len_x;
      b      = in_buf ? cmd_i.data : 8'd0;
      if (in_buf) begin
        pos_d = pos_q + PW'(1);
      end
      sh7 = 6'(cnt_d) * 6'd7;
      sh8 = {cnt_d[1:0], 3'b000};

      unique case (phase_d)
        PH_V32, PH_LEN: begin
          is_len = (phase_d == PH_LEN);
          acc_d  = acc_d | (64'(b[6:0]) << (6'(cnt_d[2:0]) * 6'd7));
          acc_d  = {32'd0, acc_d[31:0]};
          if (!b[7]) begin
            fin32 = 1'b1;
          end else if (cnt_d >= 4'd4) begin
            phase_d = is_len ? PH_LEN_SKIP : PH_V32_SKIP;
            cnt_d   = 4'd0;
          end else begin
            cnt_d = cnt_d + 4'd1;
          end
        end
        PH_V32_SKIP, PH_LEN_SKIP: begin
          is_len = (phase_d == PH_LEN_SKIP);
          cnt_d  = cnt_d + 4'd1;
          if (!b[7] || cnt_d >= 4'd5) begin
            fin32 = 1'b1;
          end
        end
        PH_V64: begin
          acc_d = acc_d | (64'(b[6:0]) << sh7);
          if (!b[7]) begin
            phase_d = PH_IDLE;
            cnt_d   = 4'd0;
            emit    = 1'b1;
            res.value_bits = acc_d;
          end else if (cnt_d >= 4'd9) begin
            phase_d = PH_IDLE;
            cnt_d   = 4'd0;
            emit    = 1'b1;
          end else begin
            cnt_d = cnt_d + 4'd1;
          end
        end
        PH_F32: begin
          acc_d = acc_d | (64'(b) << sh8);
          if (cnt_d >= 4'd3) begin
            phase_d = PH_IDLE;
            cnt_d   = 4'd0;
            emit    = 1'b1;
            res.value_bits = {32'd0, acc_d[31:0]};
          end else begin
            cnt_d = cnt_d + 4'd1;
          end
        end
        PH_PAY: begin
          if (rem_q != '0) begin
            rem_d = rem_q - vfr_pkg::LEN_W'(1);
          end
          emit             = 1'b1;
          res.result_kind  = vfr_pkg::KIND_BYTE;
          res.payload_byte = b;
          if (rem_d == '0) begin
            phase_d          = PH_IDLE;
            res.payload_last = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase

      if (fin32) begin
        v       = acc_d[31:0];
        phase_d = PH_IDLE;
        cnt_d   = 4'd0;
        pos_x   = CW'(pos_d);
        room    = (len_x > pos_x) ? (len_x - pos_x) : '0;
        if (!is_len) begin
          emit           = 1'b1;
          res.value_bits = {32'd0, v};
        end else if (!v[31] && v != 32'd0 && CW'(v) <= room) begin
          rem_d   = v[vfr_pkg::LEN_W-1:0];
          phase_d = PH_PAY;
        end else begin
          emit            = 1'b1;
          res.result_kind = vfr_pkg::KIND_EMPTY;
          res.value_bits  = {32'd0, v};
        end
      end
    end

    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take && emit) begin
      out_d       = res;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      acc_q       <= 64'd0;
      cnt_q       <= 4'd0;
      pos_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
      if (take) begin
        phase_q <= phase_d;
        acc_q   <= acc_d;
        cnt_q   <= cnt_d;
        pos_q   <= pos_d;
        rem_q   <= rem_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_pay_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY) |-> (rem_q != '0)) else $error("payload phase with no bytes left");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 4'd9) else $error("byte count out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(out_q)))
    else $error("stalled result lost");
`endif

endmodule
